FILE: design/cwv_pkg.sv
// ----------------------------------------------------------------------------
// cwv_pkg
// shared types, constants and elaboration-time functions of the
// carreau-wlf viscosity pipeline
// ----------------------------------------------------------------------------
package cwv_pkg;

    // wlf constants: c1 = 8.86 in q.16, c2 = 101.6 k in q10.8
    localparam int unsigned WLF_C1   = 580649;
    localparam int unsigned WLF_C2   = 26010;
    // log2(10) in q.16
    localparam int unsigned LOG2_TEN = 217706;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BASE   = 3'd0,
        CFG_LAMBDA = 3'd1,
        CFG_PEXP   = 3'd2,
        CFG_TSTBY  = 3'd3,
        CFG_TREF   = 3'd4
    } t_cfg_idx;

    // sideband that leaves the front stage with each item
    typedef struct packed {
        logic valid;
        logic bad;
        logic pnz;
        logic neg_a;
        logic neg_b;
    } t_side;

    // sideband kept to the output stage
    typedef struct packed {
        logic valid;
        logic bad;
    } t_tail;

    // floor integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bt;
        logic [63:0] x;
        r  = '0;
        bt = 64'h4000_0000_0000_0000;
        x  = v;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // q.30 factor 2^(2^-k), each the root of the one before, from 2.0
    function automatic logic [63:0] exp2_factor(input int k);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int j = 1; j <= k; j++) begin
            c = isqrt64(c << 30);
        end
        return c;
    endfunction

endpackage

FILE: design/cwv_delay.sv
// ----------------------------------------------------------------------------
// cwv_delay
// enabled delay line, cleared by reset
// ----------------------------------------------------------------------------
module cwv_delay #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [D];

    for (genvar k = 0; k < D; k++) begin : g_tap
        logic [W-1:0] w_in;
        if (k == 0) begin : g_first
            assign w_in = i_d;
        end else begin : g_next
            assign w_in = r_pipe[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[k] <= '0;
            end else if (i_en) begin
                r_pipe[k] <= w_in;
            end
        end
    end

    assign o_q = r_pipe[D-1];

endmodule

FILE: design/cwv_div.sv
// ----------------------------------------------------------------------------
// cwv_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cwv_div #(
    parameter int NW = 38,
    parameter int DW = 19
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_acc [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [NW-1:0] w_acc;
        logic [DW-1:0] w_den;
        logic [DW:0]   w_trial;
        logic          w_ge;
        if (k == 0) begin : g_first
            assign w_rem = '0;
            assign w_acc = i_num;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_acc = r_acc[k-1];
            assign w_den = r_den[k-1];
        end
        assign w_trial = {w_rem, w_acc[NW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DW'(w_trial - {1'b0, w_den}) : w_trial[DW-1:0];
                r_acc[k] <= {w_acc[NW-2:0], w_ge};
                r_den[k] <= w_den;
            end
        end
    end

    assign o_quo = r_acc[NW-1];

endmodule

FILE: design/cwv_log2.sv
// ----------------------------------------------------------------------------
// cwv_log2
// pipelined q.16 log2: msb search, normalize, 16 squaring stages
// ----------------------------------------------------------------------------
module cwv_log2 #(
    parameter int W  = 64,
    parameter int FB = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [W-1:0]       i_val,
    output logic signed [23:0] o_log
);

    localparam int PW = $clog2(W);

    logic [PW-1:0] w_msb;
    logic [W-1:0]  r_v;
    logic [PW-1:0] r_p0;
    logic [63:0]   w_v64;
    logic [6:0]    w_p7;
    logic [30:0]   w_m;
    logic [30:0]   r_m0;
    logic [PW-1:0] r_p1;
    logic [30:0]   r_m [16];
    logic [15:0]   r_f [16];
    logic [PW-1:0] r_p [16];
    logic signed [7:0] w_exp;

    // highest set bit
    always_comb begin
        w_msb = '0;
        for (int i = 0; i < W; i++) begin
            if (i_val[i]) begin
                w_msb = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v  <= i_val;
            r_p0 <= w_msb;
        end
    end

    // mantissa with its msb at bit 30
    assign w_v64 = 64'(r_v);
    assign w_p7  = 7'(r_p0);
    always_comb begin
        if (w_p7 >= 7'd30) begin
            w_m = 31'(w_v64 >> (w_p7 - 7'd30));
        end else begin
            w_m = 31'(w_v64 << (7'd30 - w_p7));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= w_m;
            r_p1 <= r_p0;
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_sq
        logic [30:0]   w_mi;
        logic [15:0]   w_fi;
        logic [PW-1:0] w_pi;
        logic [61:0]   w_sq;
        logic [31:0]   w_t;
        if (k == 0) begin : g_first
            assign w_mi = r_m0;
            assign w_fi = '0;
            assign w_pi = r_p1;
        end else begin : g_next
            assign w_mi = r_m[k-1];
            assign w_fi = r_f[k-1];
            assign w_pi = r_p[k-1];
        end
        assign w_sq = 62'(w_mi) * 62'(w_mi);
        assign w_t  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k] <= w_t[31] ? w_t[31:1] : w_t[30:0];
                r_f[k] <= {w_fi[14:0], w_t[31]};
                r_p[k] <= w_pi;
            end
        end
    end

    assign w_exp = $signed(8'(r_p[15])) - $signed(8'(FB));
    assign o_log = {w_exp, r_f[15]};

endmodule

FILE: design/cwv_exp2.sv
// ----------------------------------------------------------------------------
// cwv_exp2
// pipelined exp2 of a q.16 value: 16 factor stages and a final shift
// ----------------------------------------------------------------------------
module cwv_exp2 #(
    parameter int LW = 41,
    parameter int FB = 24
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [LW-1:0] i_log,
    output logic [63:0]         o_val
);

    localparam int IW = LW - 16;
    localparam logic signed [IW:0] S_OFS = (IW+1)'(FB - 30);
    localparam logic signed [IW:0] S_SAT = (IW+1)'(33);
    localparam logic signed [IW:0] S_LOW = (IW+1)'(-63);

    logic [30:0]          r_y  [16];
    logic [15:0]          r_f  [16];
    logic signed [IW-1:0] r_ip [16];
    logic signed [IW:0]   w_s;
    logic signed [IW:0]   w_neg;
    logic [63:0]          w_out;
    logic [63:0]          r_out;

    for (genvar k = 0; k < 16; k++) begin : g_fac
        localparam logic [30:0] C_K = 31'(cwv_pkg::exp2_factor(k + 1));
        logic [30:0]          w_yi;
        logic [15:0]          w_fi;
        logic signed [IW-1:0] w_ii;
        logic [61:0]          w_pr;
        if (k == 0) begin : g_first
            assign w_yi = 31'h4000_0000;
            assign w_fi = i_log[15:0];
            assign w_ii = i_log[LW-1:16];
        end else begin : g_next
            assign w_yi = r_y[k-1];
            assign w_fi = r_f[k-1];
            assign w_ii = r_ip[k-1];
        end
        assign w_pr = 62'(w_yi) * 62'(C_K);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[k]  <= w_fi[15-k] ? w_pr[60:30] : w_yi;
                r_f[k]  <= w_fi;
                r_ip[k] <= w_ii;
            end
        end
    end

    assign w_s   = $signed({r_ip[15][IW-1], r_ip[15]}) + S_OFS;
    assign w_neg = -w_s;

    always_comb begin
        if (w_s >= S_SAT) begin
            w_out = '1;
        end else if (!w_s[IW]) begin
            w_out = 64'(r_y[15]) << w_s[5:0];
        end else if (w_s <= S_LOW) begin
            w_out = '0;
        end else begin
            w_out = 64'(r_y[15]) >> w_neg[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= w_out;
        end
    end

    assign o_val = r_out;

endmodule

FILE: design/carreau_wlf_viscosity.sv
// ----------------------------------------------------------------------------
// carreau_wlf_viscosity
// per-cell kinematic viscosity nu = nuA * aT / (1 + aT*lambda*g)^C with the
// wlf shift aT = 10^(A-B), evaluated in the log2 domain in fixed point
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata: temperature, shear_rate
//  m_axis    out  tvalid / tready        tdata: viscosity, tuser: saturated
//  cfg       in   i_cfg_we (no wait)     i_cfg_idx, i_cfg_wdata
//
//  one transfer per cycle in and out while the output is not stalled; the
//  pipeline holds the 38-stage wlf dividers and the chain of
//  log2 / exp2 units (18 and 17 stages each)
//  reset clears the valid bits of every stage and loads the register defaults
//  a stall at the output freezes every stage but the base log2 in place;
//  s_axis_tready follows m_axis_tready while a result waits in the output register
//
module carreau_wlf_viscosity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [17:0] temperature, [49:18] shear_rate, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] viscosity
    output logic [0:0]  m_axis_tuser    // [0] saturated
);

    localparam logic signed [19:0] C2_Q8    = 20'sd26010;
    localparam logic signed [55:0] L2T_Q16  = 56'sd217706;
    localparam logic signed [40:0] LX_HI    = 41'sd2490368;   // 38.0
    localparam logic signed [40:0] LX_LO    = -41'sd1572864;  // -24.0
    localparam logic signed [44:0] LRES_MAX = 45'sd1048576;   // 16.0
    localparam logic [63:0]        NU_MAX   = 64'hFFFF_FFFF_FFFF;

    // configuration registers
    logic [47:0] r_cfg_base;
    logic [31:0] r_cfg_lambda;
    logic [17:0] r_cfg_pexp;
    logic [17:0] r_cfg_ts;
    logic [17:0] r_cfg_tm;

    logic w_adv;

    // stage a: input register
    logic        r_a_valid;
    logic [17:0] r_a_temp;
    logic [31:0] r_a_rate;

    // stage b: wlf numerators / denominators and lambda*g
    logic signed [18:0] w_da, w_db;
    logic signed [19:0] w_dena, w_denb;
    logic [17:0]        w_maga, w_magb;
    logic               w_bada, w_badb;
    logic [37:0]        r_b_numa, r_b_numb;
    logic [18:0]        r_b_dena, r_b_denb;
    logic [63:0]        r_b_prod;
    cwv_pkg::t_side     r_b_sb;

    // divider outputs and aligned sideband
    logic [37:0]        w_qa, w_qb;
    cwv_pkg::t_side     w_sb39;
    logic signed [23:0] w_lp, w_lp42;

    // stages e..h: shift factor in log2
    logic signed [35:0] w_ta, w_tb;
    logic signed [36:0] r_e_diff;
    logic signed [55:0] w_diff56;
    logic signed [55:0] r_f_mul;
    logic signed [55:0] w_g;
    logic signed [39:0] r_g_lat;
    logic signed [40:0] r_h_lx;

    // carreau denominator
    logic [63:0]        w_e1;
    logic [63:0]        r_j_sum;
    logic signed [23:0] w_ls;
    logic signed [40:0] w_lx79;
    logic               w_pnz79;
    logic [39:0]        r_k_den;
    logic [57:0]        r_l_cm;
    logic [57:0]        w_cm_r;
    logic [41:0]        r_m_rnd;

    // result
    logic signed [23:0] w_lb;
    logic signed [39:0] w_lat82;
    logic signed [44:0] r_n_lres;
    logic               r_o1_ovf;
    logic               w_ovf100;
    logic [63:0]        w_nu;
    cwv_pkg::t_tail     w_tail39, w_tail100;

    logic        r_o_valid;
    logic [47:0] r_o_visc;
    logic        r_o_sat;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base   <= 48'h0001_0000_0000;
            r_cfg_lambda <= '0;
            r_cfg_pexp   <= '0;
            r_cfg_ts     <= '0;
            r_cfg_tm     <= '0;
        end else if (i_cfg_we) begin
            case (cwv_pkg::t_cfg_idx'(i_cfg_idx))
                cwv_pkg::CFG_BASE:   r_cfg_base   <= i_cfg_wdata;
                cwv_pkg::CFG_LAMBDA: r_cfg_lambda <= i_cfg_wdata[31:0];
                cwv_pkg::CFG_PEXP:   r_cfg_pexp   <= i_cfg_wdata[17:0];
                cwv_pkg::CFG_TSTBY:  r_cfg_ts     <= i_cfg_wdata[17:0];
                cwv_pkg::CFG_TREF:   r_cfg_tm     <= i_cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves whenever the output register can take
    assign w_adv         = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ---------------- stage a ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_temp <= s_axis_tdata[17:0];
            r_a_rate <= s_axis_tdata[49:18];
        end
    end

    // ---------------- stage b ----------------
    // A uses the reference temperature, B the cell temperature
    assign w_da   = $signed({1'b0, r_cfg_tm}) - $signed({1'b0, r_cfg_ts});
    assign w_db   = $signed({1'b0, r_a_temp}) - $signed({1'b0, r_cfg_ts});
    assign w_dena = C2_Q8 + $signed({w_da[18], w_da});
    assign w_denb = C2_Q8 + $signed({w_db[18], w_db});
    assign w_bada = w_dena[19] || (w_dena == '0);
    assign w_badb = w_denb[19] || (w_denb == '0);
    assign w_maga = w_da[18] ? 18'(-w_da) : w_da[17:0];
    assign w_magb = w_db[18] ? 18'(-w_db) : w_db[17:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_sb <= '0;
        end else if (w_adv) begin
            r_b_sb.valid <= r_a_valid;
            r_b_sb.bad   <= w_bada || w_badb;
            r_b_sb.pnz   <= (r_cfg_lambda != '0) && (r_a_rate != '0);
            r_b_sb.neg_a <= w_da[18];
            r_b_sb.neg_b <= w_db[18];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_numa <= 38'(cwv_pkg::WLF_C1) * 38'(w_maga);
            r_b_numb <= 38'(cwv_pkg::WLF_C1) * 38'(w_magb);
            r_b_dena <= w_dena[18:0];
            r_b_denb <= w_denb[18:0];
            r_b_prod <= 64'(r_cfg_lambda) * 64'(r_a_rate);
        end
    end

    // wlf quotients, magnitude only
    cwv_div #(.NW(38), .DW(19)) u_div_a (
        .i_clk (i_clk), .i_en (w_adv), .i_num (r_b_numa), .i_den (r_b_dena), .o_quo (w_qa)
    );

    cwv_div #(.NW(38), .DW(19)) u_div_b (
        .i_clk (i_clk), .i_en (w_adv), .i_num (r_b_numb), .i_den (r_b_denb), .o_quo (w_qb)
    );

    cwv_delay #(.W($bits(cwv_pkg::t_side)), .D(38)) u_sb_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (r_b_sb), .o_q (w_sb39)
    );

    // log2 of lambda*g (q.32), lined up with the quotients
    cwv_log2 #(.W(64), .FB(32)) u_log_prod (
        .i_clk (i_clk), .i_en (w_adv), .i_val (r_b_prod), .o_log (w_lp)
    );

    cwv_delay #(.W(24), .D(23)) u_lp_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (w_lp), .o_q (w_lp42)
    );

    // ---------------- stages e..h ----------------
    assign w_ta = w_sb39.neg_a ? -$signed({1'b0, w_qa[34:0]}) : $signed({1'b0, w_qa[34:0]});
    assign w_tb = w_sb39.neg_b ? -$signed({1'b0, w_qb[34:0]}) : $signed({1'b0, w_qb[34:0]});
    assign w_diff56 = {{19{r_e_diff[36]}}, r_e_diff};
    // round half away from zero then drop 16 bits
    assign w_g = r_f_mul + (r_f_mul[55] ? 56'sd32767 : 56'sd32768);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_diff <= $signed({w_ta[35], w_ta}) - $signed({w_tb[35], w_tb});
            r_f_mul  <= w_diff56 * L2T_Q16;
            r_g_lat  <= w_g[55:16];
            r_h_lx   <= $signed({r_g_lat[39], r_g_lat}) + $signed({{17{w_lp42[23]}}, w_lp42});
        end
    end

    // ---------------- carreau denominator ----------------
    cwv_exp2 #(.LW(41), .FB(24)) u_exp_x (
        .i_clk (i_clk), .i_en (w_adv), .i_log (r_h_lx), .o_val (w_e1)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j_sum <= w_e1 + 64'h0100_0000;
        end
    end

    cwv_log2 #(.W(64), .FB(24)) u_log_sum (
        .i_clk (i_clk), .i_en (w_adv), .i_val (r_j_sum), .o_log (w_ls)
    );

    cwv_delay #(.W(41), .D(36)) u_lx_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (r_h_lx), .o_q (w_lx79)
    );

    cwv_delay #(.W(1), .D(40)) u_pnz_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (w_sb39.pnz), .o_q (w_pnz79)
    );

    assign w_cm_r = r_l_cm + 58'd32768;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // large x: log2(1+x) taken as log2(x); tiny x: taken as zero
            if (!w_pnz79) begin
                r_k_den <= '0;
            end else if (w_lx79 >= LX_HI) begin
                r_k_den <= w_lx79[39:0];
            end else if (w_lx79 >= LX_LO) begin
                r_k_den <= {16'b0, w_ls};
            end else begin
                r_k_den <= '0;
            end
            r_l_cm  <= 58'(r_cfg_pexp) * 58'(r_k_den);
            r_m_rnd <= w_cm_r[57:16];
        end
    end

    // ---------------- result ----------------
    // log2 of the base viscosity runs freely off the register
    cwv_log2 #(.W(48), .FB(32)) u_log_base (
        .i_clk (i_clk), .i_en (1'b1), .i_val (r_cfg_base), .o_log (w_lb)
    );

    cwv_delay #(.W(40), .D(40)) u_lat_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (r_g_lat), .o_q (w_lat82)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n_lres <= $signed({{21{w_lb[23]}}, w_lb}) + $signed({{5{w_lat82[39]}}, w_lat82})
                        - $signed({3'b0, r_m_rnd});
            r_o1_ovf <= (r_n_lres >= LRES_MAX);
        end
    end

    cwv_exp2 #(.LW(45), .FB(32)) u_exp_nu (
        .i_clk (i_clk), .i_en (w_adv), .i_log (r_n_lres), .o_val (w_nu)
    );

    cwv_delay #(.W(1), .D(16)) u_ovf_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (r_o1_ovf), .o_q (w_ovf100)
    );

    assign w_tail39.valid = w_sb39.valid;
    assign w_tail39.bad   = w_sb39.bad;

    cwv_delay #(.W($bits(cwv_pkg::t_tail)), .D(61)) u_tail_dly (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv), .i_d (w_tail39), .o_q (w_tail100)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= w_tail100.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_tail100.bad) begin
                // wlf denominator not positive
                r_o_visc <= '1;
                r_o_sat  <= 1'b1;
            end else if (r_cfg_base == '0) begin
                r_o_visc <= '0;
                r_o_sat  <= 1'b0;
            end else if (w_ovf100 || (w_nu > NU_MAX)) begin
                r_o_visc <= '1;
                r_o_sat  <= 1'b1;
            end else begin
                r_o_visc <= w_nu[47:0];
                r_o_sat  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = r_o_visc;
    assign m_axis_tuser[0] = r_o_sat;

endmodule

FILE: design/cwv_checker.sv
// ----------------------------------------------------------------------------
// cwv_checker
// port-level checks of the viscosity pipeline
// ----------------------------------------------------------------------------
module cwv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a saturated result is always the clamp value
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 48'hFFFF_FFFF_FFFF))
        else $error("saturated result not clamped");

    // an empty output register never holds back the input
    a_rdy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // input ready only when the output side can move
    a_rdy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind carreau_wlf_viscosity cwv_checker u_cwv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
